// File: design/angular_falloff_table_interpolator_defines.svh
// ----------------------------------------------------------------------------
// angular falloff table interpolator: assertion macros
// concurrent checks on the clock and reset of the module that uses them
// ----------------------------------------------------------------------------
`ifndef ANGULAR_FALLOFF_TABLE_INTERPOLATOR_DEFINES_SVH
`define ANGULAR_FALLOFF_TABLE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AFTI_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("afti assertion failed");
// next-cycle implication
`define AFTI_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("afti assertion failed");
`else
`define AFTI_ASSERT_NOW(lbl, ante, cons)
`define AFTI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/afti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afti_pkg
// shared types, constants and the arctangent step table
// ----------------------------------------------------------------------------
package afti_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int CNT_W        = 5;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int ROOT_STEPS   = 24;
   localparam int CORDIC_STEPS = 24;
   localparam int DIV_STEPS    = 37;
   localparam int VEC_W        = 28;
   localparam int ACC_W        = 32;

   localparam logic [15:0] ANGLE_MAX = 16'd51472;
   localparam logic [15:0] VALUE_ONE = 16'd32768;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q24 = 32'sd26353589;

   localparam logic MODE_EVAL = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // one queued word, classified by the front
   typedef struct packed {
      logic               mode;
      logic               zero_dir;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [IDX_W-1:0]   entry_index;
      logic [15:0]        entry_angle;
      logic [15:0]        entry_value;
   } item_type;

   typedef struct packed {
      logic [15:0] falloff;
      logic [15:0] angle;
      logic        beyond_cutoff;
      logic        bad_input;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL, ST_ROOT_INIT, ST_ROOT, ST_CORD_INIT, ST_CORD, ST_THETA,
      ST_SCAN_RD, ST_SCAN_CHK, ST_LO_RD, ST_LO_CHK, ST_HI_RD, ST_HI_CHK,
      ST_PROD, ST_DIV_INIT, ST_DIV, ST_FIX, ST_DONE
   } state_type;

   // round(atan(2^-i) * 2^24), exact power of two past step seven
   function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] i);
      case (i)
         5'd0:    atan_step = 32'sd13176795;
         5'd1:    atan_step = 32'sd7778716;
         5'd2:    atan_step = 32'sd4110060;
         5'd3:    atan_step = 32'sd2086331;
         5'd4:    atan_step = 32'sd1047214;
         5'd5:    atan_step = 32'sd524117;
         5'd6:    atan_step = 32'sd262123;
         5'd7:    atan_step = 32'sd131069;
         default: atan_step = $signed(32'd1 << (5'd24 - i));
      endcase
   endfunction

endpackage

// File: design/afti_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afti request and response channels
// valid/ready handshake with the word payload
// ----------------------------------------------------------------------------
interface afti_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [3:0]         entry_index;
   logic [15:0]        entry_angle;
   logic [15:0]        entry_value;

   modport source (output valid, mode, dir_x, dir_y, dir_z, entry_index,
                   entry_angle, entry_value, input ready);
   modport sink   (input valid, mode, dir_x, dir_y, dir_z, entry_index,
                   entry_angle, entry_value, output ready);
endinterface

interface afti_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] falloff;
   logic [15:0] angle;
   logic        beyond_cutoff;
   logic        bad_input;

   modport source (output valid, falloff, angle, beyond_cutoff, bad_input,
                   input ready);
   modport sink   (input valid, falloff, angle, beyond_cutoff, bad_input,
                   output ready);
endinterface

// File: design/afti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afti_front
// accepts request words, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module afti_front (
   input  logic              clock,
   input  logic              reset,
   afti_req_if.sink          req,
   output afti_pkg::item_type q_item,
   output logic              q_valid,
   input  logic              q_pop
);
   import afti_pkg::*;

   item_type            fifo_mem [QUEUE_DEPTH];
   item_type            new_item;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;
   logic                pop;

   // classify the incoming word
   always_comb begin
      new_item.mode        = req.mode;
      new_item.zero_dir    = (req.dir_x == 16'sd0) && (req.dir_y == 16'sd0) &&
                             (req.dir_z == 16'sd0);
      new_item.dir_x       = req.dir_x;
      new_item.dir_y       = req.dir_y;
      new_item.dir_z       = req.dir_z;
      new_item.entry_index = req.entry_index[IDX_W-1:0];
      new_item.entry_angle = req.entry_angle;
      new_item.entry_value = req.entry_value;
   end

   // queue control
   assign req.ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = fifo_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: design/afti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afti_back
// sequencer: table writes, square root, cordic angle, interval search,
// interpolation with a bit-serial divider, and the response register
// ----------------------------------------------------------------------------
`include "angular_falloff_table_interpolator_defines.svh"

module afti_back (
   input  logic                           clock,
   input  logic                           reset,
   input  afti_pkg::item_type             q_item,
   input  logic                           q_valid,
   output logic                           q_pop,
   input  logic [afti_pkg::CNT_W-1:0]     entry_count,
   afti_rsp_if.source                     rsp
);
   import afti_pkg::*;

   state_type state_ff, state_in;

   // table memories
   logic [15:0]      angle_mem [TABLE_DEPTH];
   logic [15:0]      value_mem [TABLE_DEPTH];
   logic [15:0]      angle_rd_ff;
   logic [15:0]      value_rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   // datapath registers
   logic signed [15:0]      x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [31:0]             xx_ff, xx_in, yy_ff, yy_in;
   logic [47:0]             rad_ff, rad_in;
   logic [25:0]             rem_ff, rem_in;
   logic [23:0]             root_ff, root_in;
   logic signed [VEC_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [15:0]             theta_ff, theta_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic [15:0]             a0_ff, a0_in, v0_ff, v0_in, a1_ff, a1_in, v1_ff, v1_in;
   logic signed [33:0]      prod_ff, prod_in;
   logic [16:0]             den_ff, den_in;
   logic                    den_neg_ff, den_neg_in;
   logic                    neg_ff, neg_in;
   logic [36:0]             quo_ff, quo_in;
   logic [17:0]             drem_ff, drem_in;
   logic [17:0]             dvs_ff, dvs_in;
   result_type              res_ff, res_in;
   result_type              out_ff, out_in;
   logic                    out_vld_ff, out_vld_in;

   // combinational helpers
   logic [CNT_W-1:0]        n_cnt;
   logic [IDX_W-1:0]        last_idx;
   logic                    out_free;
   logic [27:0]             sq_t, sq_trial;
   logic signed [VEC_W-1:0] cd_dx, cd_dy, z_vec;
   logic signed [ACC_W-1:0] cd_step, acc_rnd;
   logic signed [16:0]      d_theta, d_val, d_ang;
   logic signed [34:0]      num_s;
   logic signed [36:0]      nn_s;
   logic [17:0]             dv_t;
   logic [37:0]             q_mag;
   logic signed [38:0]      q_s;
   logic signed [39:0]      f_s;

   // clamp the entry count to the table
   always_comb begin
      if (entry_count < CNT_W'(2)) begin
         n_cnt = CNT_W'(2);
      end else if (entry_count > CNT_W'(TABLE_DEPTH)) begin
         n_cnt = CNT_W'(TABLE_DEPTH);
      end else begin
         n_cnt = entry_count;
      end
      last_idx = IDX_W'(n_cnt - 1'b1);
   end

   assign out_free = !out_vld_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.mode == MODE_LOAD || q_item.zero_dir) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL:       state_in = ST_ROOT_INIT;
         ST_ROOT_INIT: state_in = ST_ROOT;
         ST_ROOT: begin
            if (cnt_ff == 6'(ROOT_STEPS - 1)) state_in = ST_CORD_INIT;
         end
         ST_CORD_INIT: state_in = ST_CORD;
         ST_CORD: begin
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) state_in = ST_THETA;
         end
         ST_THETA:   state_in = ST_SCAN_RD;
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (cnt_ff[IDX_W-1:0] == last_idx) begin
               state_in = (theta_ff > angle_rd_ff) ? ST_DONE : ST_LO_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_LO_RD:  state_in = ST_LO_CHK;
         ST_LO_CHK: state_in = ST_HI_RD;
         ST_HI_RD:  state_in = ST_HI_CHK;
         ST_HI_CHK: state_in = ST_PROD;
         ST_PROD:   state_in = (a1_ff == a0_ff) ? ST_DONE : ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_FIX;
         end
         ST_FIX:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop   = 1'b0;
      mem_we  = 1'b0;
      rd_addr = cnt_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            q_pop  = q_valid;
            mem_we = q_valid && (q_item.mode == MODE_LOAD);
         end
         ST_LO_RD: rd_addr = best_ff;
         ST_HI_RD: rd_addr = best_ff + 1'b1;
         default:  rd_addr = cnt_ff[IDX_W-1:0];
      endcase
   end

   // datapath
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      xx_in = xx_ff; yy_in = yy_ff;
      rad_in = rad_ff; rem_in = rem_ff; root_in = root_ff;
      vx_in = vx_ff; vy_in = vy_ff; acc_in = acc_ff;
      cnt_in = cnt_ff; theta_in = theta_ff; best_in = best_ff;
      a0_in = a0_ff; v0_in = v0_ff; a1_in = a1_ff; v1_in = v1_ff;
      prod_in = prod_ff; den_in = den_ff; den_neg_in = den_neg_ff;
      neg_in = neg_ff; quo_in = quo_ff; drem_in = drem_ff; dvs_in = dvs_ff;
      res_in = res_ff;

      // square root digit
      sq_t     = {rem_ff, rad_ff[47:46]};
      sq_trial = {2'b00, root_ff, 2'b01};

      // cordic micro-rotation
      cd_dx   = vy_ff >>> cnt_ff[4:0];
      cd_dy   = vx_ff >>> cnt_ff[4:0];
      cd_step = atan_step(cnt_ff[4:0]);
      z_vec   = VEC_W'($signed({z_ff, 8'd0}));
      acc_rnd = (acc_ff + 32'sd512) >>> 10;

      // interpolation terms
      d_theta = $signed({1'b0, theta_ff}) - $signed({1'b0, a0_ff});
      d_val   = $signed({1'b0, v1_ff}) - $signed({1'b0, v0_ff});
      d_ang   = $signed({1'b0, a1_ff}) - $signed({1'b0, a0_ff});
      num_s   = den_neg_ff ? -{prod_ff[33], prod_ff} : {prod_ff[33], prod_ff};
      nn_s    = $signed({num_s[34], num_s, 1'b0}) + $signed({20'd0, den_ff});
      dv_t    = {drem_ff[16:0], quo_ff[36]};
      q_mag   = {1'b0, quo_ff} + {37'd0, (neg_ff && (drem_ff != '0))};
      q_s     = neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
      f_s     = $signed({q_s[38], q_s}) + $signed({24'd0, v0_ff});

      case (state_ff)
         ST_IDLE: begin
            res_in = '0;
            if (q_valid) begin
               if (q_item.mode == MODE_EVAL && q_item.zero_dir) begin
                  res_in.bad_input = 1'b1;
               end
               x_in = q_item.dir_x;
               y_in = q_item.dir_y;
               z_in = q_item.dir_z;
            end
         end
         ST_MUL: begin
            xx_in = 32'(x_ff) * 32'(x_ff);
            yy_in = 32'(y_ff) * 32'(y_ff);
         end
         ST_ROOT_INIT: begin
            rad_in  = {xx_ff + yy_ff, 16'd0};
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         ST_ROOT: begin
            rad_in = {rad_ff[45:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (sq_t >= sq_trial) begin
               rem_in  = 26'(sq_t - sq_trial);
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               rem_in  = sq_t[25:0];
               root_in = {root_ff[22:0], 1'b0};
            end
         end
         ST_CORD_INIT: begin
            cnt_in = '0;
            if (z_ff[15]) begin
               vx_in  = $signed({4'd0, root_ff});
               vy_in  = -z_vec;
               acc_in = HALF_PI_Q24;
            end else begin
               vx_in  = z_vec;
               vy_in  = $signed({4'd0, root_ff});
               acc_in = '0;
            end
         end
         ST_CORD: begin
            cnt_in = cnt_ff + 1'b1;
            if (!vy_ff[VEC_W-1]) begin
               vx_in  = vx_ff + cd_dx;
               vy_in  = vy_ff - cd_dy;
               acc_in = acc_ff + cd_step;
            end else begin
               vx_in  = vx_ff - cd_dx;
               vy_in  = vy_ff + cd_dy;
               acc_in = acc_ff - cd_step;
            end
         end
         ST_THETA: begin
            cnt_in  = '0;
            best_in = '0;
            if (acc_rnd[ACC_W-1]) begin
               theta_in = '0;
            end else if (acc_rnd > $signed({16'd0, ANGLE_MAX})) begin
               theta_in = ANGLE_MAX;
            end else begin
               theta_in = acc_rnd[15:0];
            end
            res_in.angle = '0;
         end
         ST_SCAN_CHK: begin
            res_in.angle = theta_ff;
            if (cnt_ff[IDX_W-1:0] == last_idx) begin
               if (theta_ff > angle_rd_ff) begin
                  res_in.beyond_cutoff = 1'b1;
               end
            end else begin
               if (angle_rd_ff <= theta_ff) begin
                  best_in = cnt_ff[IDX_W-1:0];
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LO_CHK: begin
            a0_in = angle_rd_ff;
            v0_in = value_rd_ff;
         end
         ST_HI_CHK: begin
            a1_in = angle_rd_ff;
            v1_in = value_rd_ff;
         end
         ST_PROD: begin
            prod_in    = d_theta * d_val;
            den_neg_in = d_ang[16];
            den_in     = d_ang[16] ? 17'(-d_ang) : 17'(d_ang);
            if (a1_ff == a0_ff) begin
               res_in.bad_input = 1'b1;
            end
         end
         ST_DIV_INIT: begin
            neg_in  = nn_s[36];
            quo_in  = nn_s[36] ? 37'(-nn_s) : 37'(nn_s);
            drem_in = '0;
            dvs_in  = {den_ff, 1'b0};
            cnt_in  = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (dv_t >= dvs_ff) begin
               drem_in = dv_t - dvs_ff;
               quo_in  = {quo_ff[35:0], 1'b1};
            end else begin
               drem_in = dv_t;
               quo_in  = {quo_ff[35:0], 1'b0};
            end
         end
         ST_FIX: begin
            if (f_s[39]) begin
               res_in.falloff = '0;
            end else if (f_s > $signed({24'd0, VALUE_ONE})) begin
               res_in.falloff = VALUE_ONE;
            end else begin
               res_in.falloff = f_s[15:0];
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (out_vld_ff && rsp.ready) begin
         out_vld_in = 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         out_in     = res_ff;
         out_vld_in = 1'b1;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.falloff       = out_ff.falloff;
   assign rsp.angle         = out_ff.angle;
   assign rsp.beyond_cutoff = out_ff.beyond_cutoff;
   assign rsp.bad_input     = out_ff.bad_input;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      xx_ff <= xx_in; yy_ff <= yy_in;
      rad_ff <= rad_in; rem_ff <= rem_in; root_ff <= root_in;
      vx_ff <= vx_in; vy_ff <= vy_in; acc_ff <= acc_in;
      cnt_ff <= cnt_in; theta_ff <= theta_in; best_ff <= best_in;
      a0_ff <= a0_in; v0_ff <= v0_in; a1_ff <= a1_in; v1_ff <= v1_in;
      prod_ff <= prod_in; den_ff <= den_in; den_neg_ff <= den_neg_in;
      neg_ff <= neg_in; quo_ff <= quo_in; drem_ff <= drem_in; dvs_ff <= dvs_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   // table memories, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         angle_mem[q_item.entry_index] <= q_item.entry_angle;
         value_mem[q_item.entry_index] <= q_item.entry_value;
      end
      angle_rd_ff <= angle_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   // checks
   `AFTI_ASSERT_NEXT(a_load_to_done, (state_ff == ST_IDLE && q_valid && q_item.mode == MODE_LOAD), (state_ff == ST_DONE))
   `AFTI_ASSERT_NOW(a_beyond_gives_zero, (out_vld_ff && out_ff.beyond_cutoff), (out_ff.falloff == 16'd0 && !out_ff.bad_input))
   `AFTI_ASSERT_NOW(a_result_range, out_vld_ff, (out_ff.falloff <= VALUE_ONE && out_ff.angle <= ANGLE_MAX))

endmodule

// File: design/angular_falloff_table_interpolator.sv
`timescale 1ns / 1ps
// sequence: a load word writes the table; an evaluate word runs the 24-step root,
//   the 24-step cordic, a scan over the n table entries (n = clamped entry_count)
//   and at most the 37-step divider in the back sequencer
// capacity: one word in the back at a time, two more held in the queue
// reset: synchronous, clears queue, sequencer and response valid; entry_count 2
// ----------------------------------------------------------------------------
// angular_falloff_table_interpolator
// top level: front queue, back sequencer and the entry count register
// ----------------------------------------------------------------------------
module angular_falloff_table_interpolator (
   input  logic       clock,
   input  logic       reset,
   afti_req_if.sink   req,
   afti_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);
   import afti_pkg::*;

   item_type         q_item;
   logic             q_valid;
   logic             q_pop;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;

   // entry count register
   assign entry_count_in = csr_wr_en ? csr_wr_data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= CNT_W'(2);
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // front: accept and classify
   afti_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // back: execute and respond
   afti_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_item      (q_item),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .entry_count (entry_count_ff),
      .rsp         (rsp)
   );

endmodule
